FILE: src/rth_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RGB to HSL converter.
// No dependencies; used by every other file in src.
package rth_pkg;

  localparam int ChanW   = 8;   // input channel width
  localparam int HueW    = 16;  // hue result width
  localparam int FracW   = 17;  // saturation / lightness width
  localparam int QuoW    = 18;  // quotient bits: one integer bit and 17 fraction bits
  localparam int DvsW    = 11;  // divisor width, largest divisor is 6*255
  localparam int RemW    = 12;  // partial remainder, below twice the divisor
  localparam int NumLanes = 3;

  // lane order inside the divider chain
  localparam int LaneHue = 0;
  localparam int LaneSat = 1;
  localparam int LaneLig = 2;

  // full-scale lightness divisor, 2*255
  localparam logic [DvsW-1:0] LigDvs = DvsW'(510);

  // one division in flight: partial remainder, divisor, quotient so far
  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [DvsW-1:0] dvs;
    logic [QuoW-1:0] quo;
  } lane_t;

  typedef lane_t [NumLanes-1:0] lanes_t;

endpackage

FILE: src/rth_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pixels in and HSL results out.
// Depends on rth_pkg for field widths.
interface rth_pix_if;
  logic                       valid;
  logic                       ready;
  logic [rth_pkg::ChanW-1:0]  red;
  logic [rth_pkg::ChanW-1:0]  green;
  logic [rth_pkg::ChanW-1:0]  blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rth_hsl_if;
  logic                       valid;
  logic                       ready;
  logic [rth_pkg::HueW-1:0]   hue;
  logic [rth_pkg::FracW-1:0]  saturation;
  logic [rth_pkg::FracW-1:0]  lightness;
  modport source (output valid, hue, saturation, lightness, input ready);
  modport sink   (input valid, hue, saturation, lightness, output ready);
endinterface

FILE: src/rth_front.sv
`timescale 1ns / 1ps
// Front cell: max/min, spread and the three dividend/divisor pairs.
// Depends on rth_pkg; feeds the first rth_div_cell.
module rth_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [rth_pkg::ChanW-1:0] red,
  input  logic [rth_pkg::ChanW-1:0] green,
  input  logic [rth_pkg::ChanW-1:0] blue,
  output logic                      vld_r,
  output rth_pkg::lanes_t           lanes_r
);

  logic [rth_pkg::ChanW-1:0] mx, mn, d;
  logic [8:0]                sum;
  logic [rth_pkg::DvsW-1:0]  d6, hnum, sden;
  logic                      grey;
  rth_pkg::lanes_t           lanes_nxt;
  logic                      vld_nxt;

  // find extremes and derived terms
  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx)  mx = blue;
    if (green < mn) mn = green;
    if (blue < mn)  mn = blue;
    d    = mx - mn;
    sum  = {1'b0, mx} + {1'b0, mn};
    grey = (mx == mn);
    d6   = {2'b00, d, 1'b0} + {1'b0, d, 2'b00};
    sden = (sum > 9'd255) ? (rth_pkg::DvsW'(510) - {2'b00, sum}) : {2'b00, sum};
    if (mx == red) begin
      if (green >= blue) hnum = {3'b000, green - blue};
      else               hnum = d6 - {3'b000, blue - green};
    end else if (mx == green) begin
      hnum = {2'b00, d, 1'b0} + {3'b000, blue} - {3'b000, red};
    end else begin
      hnum = {1'b0, d, 2'b00} + {3'b000, red} - {3'b000, green};
    end
  end

  // load the lanes; a grey pixel divides zero by one in the hue and saturation lanes
  always_comb begin
    lanes_nxt = '0;
    lanes_nxt[rth_pkg::LaneHue].rem = grey ? '0 : {1'b0, hnum};
    lanes_nxt[rth_pkg::LaneHue].dvs = grey ? rth_pkg::DvsW'(1) : d6;
    lanes_nxt[rth_pkg::LaneSat].rem = grey ? '0 : rth_pkg::RemW'(d);
    lanes_nxt[rth_pkg::LaneSat].dvs = grey ? rth_pkg::DvsW'(1) : sden;
    lanes_nxt[rth_pkg::LaneLig].rem = rth_pkg::RemW'(sum);
    lanes_nxt[rth_pkg::LaneLig].dvs = rth_pkg::LigDvs;
    vld_nxt = in_vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lanes_r <= lanes_nxt;
    end
  end

endmodule

FILE: src/rth_div_cell.sv
`timescale 1ns / 1ps
// Divider cell: one restoring quotient bit for each of the three lanes.
// Depends on rth_pkg; chained in the top level.
module rth_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  rth_pkg::lanes_t lanes_i,
  output logic            vld_r,
  output rth_pkg::lanes_t lanes_r
);

  rth_pkg::lanes_t lanes_nxt;

  // compare, subtract, double, shift in the quotient bit
  always_comb begin
    for (int l = 0; l < rth_pkg::NumLanes; l++) begin
      logic                     bit_q;
      logic [rth_pkg::RemW-1:0] diff;
      bit_q = (lanes_i[l].rem >= {1'b0, lanes_i[l].dvs});
      diff  = bit_q ? (lanes_i[l].rem - {1'b0, lanes_i[l].dvs}) : lanes_i[l].rem;
      lanes_nxt[l].rem = {diff[rth_pkg::RemW-2:0], 1'b0};
      lanes_nxt[l].dvs = lanes_i[l].dvs;
      lanes_nxt[l].quo = {lanes_i[l].quo[rth_pkg::QuoW-2:0], bit_q};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lanes_r <= lanes_nxt;
    end
  end

endmodule

FILE: src/rgb_to_hsl_converter.sv
`timescale 1ns / 1ps
// Top level of the RGB to HSL converter: front cell, divider cell chain, output register.
// Depends on rth_pkg, rth_if, rth_front and rth_div_cell.
//
//   channel  | beat fields                        | handshake
//   in_pix   | red, green, blue (8 bits each)     | valid / ready
//   out_hsl  | hue 16, saturation 17, lightness 17| valid / ready
//
// One pixel per cycle sustained while the output does not stall; an accepted
// input beat passes through 20 register stages (front cell, 18 divider
// cells, output register), the cell count set by the 18 quotient bits.
// Synchronous active-low reset clears all valid bits.
// A stalled output register freezes the whole chain; in_pix.ready is
// low only while a result waits and out_hsl.ready is low.
module rgb_to_hsl_converter (
  input logic       clk,
  input logic       rst_n,
  rth_pix_if.sink   in_pix,
  rth_hsl_if.source out_hsl
);

  localparam int NCells = rth_pkg::QuoW;

  logic                        en;
  logic                        vld [0:NCells];
  rth_pkg::lanes_t             stg [0:NCells];
  logic                        out_vld_r;
  logic [rth_pkg::HueW-1:0]    hue_r, hue_nxt;
  logic [rth_pkg::FracW-1:0]   sat_r, sat_nxt, lig_r, lig_nxt;
  logic [rth_pkg::HueW:0]      hue_rnd;

  // advance the chain unless a result is held
  assign en           = !out_vld_r || out_hsl.ready;
  assign in_pix.ready = en;

  rth_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_pix.valid),
    .red     (in_pix.red),
    .green   (in_pix.green),
    .blue    (in_pix.blue),
    .vld_r   (vld[0]),
    .lanes_r (stg[0])
  );

  for (genvar i = 0; i < NCells; i++) begin : g_cell
    rth_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_i   (vld[i]),
      .lanes_i (stg[i]),
      .vld_r   (vld[i+1]),
      .lanes_r (stg[i+1])
    );
  end

  // round half up from the extra quotient bit; wrap a full-turn hue
  always_comb begin
    hue_rnd = (rth_pkg::HueW+1)'(({1'b0, stg[NCells][rth_pkg::LaneHue].quo} + 19'd1) >> 1);
    sat_nxt = rth_pkg::FracW'(({1'b0, stg[NCells][rth_pkg::LaneSat].quo} + 19'd1) >> 1);
    lig_nxt = rth_pkg::FracW'(({1'b0, stg[NCells][rth_pkg::LaneLig].quo} + 19'd1) >> 1);
    hue_nxt = hue_rnd[rth_pkg::HueW] ? '0 : hue_rnd[rth_pkg::HueW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld[NCells];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      lig_r <= lig_nxt;
    end
  end

  assign out_hsl.valid      = out_vld_r;
  assign out_hsl.hue        = hue_r;
  assign out_hsl.saturation = sat_r;
  assign out_hsl.lightness  = lig_r;

`ifndef SYNTHESIS
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (sat_r <= 17'd65536)) else $error("saturation above full scale");
  a_lig_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (lig_r <= 17'd65536)) else $error("lightness above full scale");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_hsl.ready) |=> ($stable(vld[NCells]) && out_vld_r && $stable(hue_r)))
    else $error("chain moved while output held");
  a_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(vld[NCells])) else $error("result without source beat");
`endif

endmodule
